// ----- hdl/hpr_pkg.sv -----
package hpr_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_DECIDE,
    ST_SUM,
    ST_SUMWAIT,
    ST_DIV,
    ST_DONE
  } hpr_state_t;

  localparam int USER_SLOTS = 65536;
  localparam int PAGE_SLOTS = 1024;
  localparam int FRAC_BITS  = 20;
  localparam int OUT_W      = 21;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic update;
    logic sum_start;
    logic sum_step;
    logic div_start;
    logic div_step;
    logic emit;
  } hpr_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_query;
    logic valid_rec;
    logic unknown;
    logic one_user;
    logic sum_done;
    logic div_done;
  } hpr_stat_t;

endpackage

// ----- hdl/histogram_percentile_rank_core.sv -----
// Pages-read histogram with percentile rank queries. Pulse start while busy
// is low to issue a request: in_action 0 records in_page_count for
// in_user_id, 1 queries the rank. After reset, busy stays high while both
// memories are cleared over max(USER_SLOTS, PAGE_SLOTS) = 65536 addresses.
// A record keeps busy high after it is accepted while the user's old page
// count is fetched and then while the old and new histogram buckets are
// updated; a record with a page count of zero is dropped without an update.
// A query for an unknown user, or while only one user is known, answers on
// out_valid without a bucket sweep or division. Any other query answers
// after setup, a sweep over buckets 1 to mine-1, where mine is the user's
// page count, reading one histogram entry a cycle, a restoring division
// making one quotient bit a cycle and the load of the result. The next
// request may be accepted in the cycle out_valid is high. The receiver
// cannot stall: each result is flagged on out_valid for exactly one cycle.
module histogram_percentile_rank_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_action,
  input  logic [15:0]               in_user_id,
  input  logic [9:0]                in_page_count,
  output logic                      out_valid,
  output logic [hpr_pkg::OUT_W-1:0] out_rank_fraction
);

  import hpr_pkg::*;

  hpr_cmd_t  cmd;
  hpr_stat_t stat;
  logic      ctrl_busy;
  logic [2:0] hold_r;

  // hold off new requests while the histogram update finishes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
    end else if (cmd.update) begin
      hold_r <= 3'd4;
    end else if (hold_r != '0) begin
      hold_r <= hold_r - 1'b1;
    end
  end

  assign busy = ctrl_busy || (hold_r != '0);

  hpr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start && (hold_r == '0)),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (ctrl_busy)
  );

  hpr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_action         (in_action),
    .in_user_id        (in_user_id),
    .in_page_count     (in_page_count),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_rank_fraction (out_rank_fraction)
  );

endmodule

// ----- hdl/hpr_ram.sv -----
module hpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/hpr_ctrl.sv -----
module hpr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  hpr_pkg::hpr_stat_t stat,
  output hpr_pkg::hpr_cmd_t  cmd,
  output logic               busy
);

  import hpr_pkg::*;

  hpr_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!stat.is_query) begin
          cmd.update = stat.valid_rec;
          state_nxt = ST_IDLE;
        end else if (stat.unknown || stat.one_user) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.sum_start = 1'b1;
          state_nxt = ST_SUMWAIT;
        end
      end
      ST_SUMWAIT: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (stat.sum_done) begin
          state_nxt = ST_DIV;
          cmd.div_start = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.emit = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/hpr_dp.sv -----
module hpr_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_action,
  input  logic [15:0]                in_user_id,
  input  logic [9:0]                 in_page_count,
  input  hpr_pkg::hpr_cmd_t          cmd,
  output hpr_pkg::hpr_stat_t         stat,
  output logic                       out_valid,
  output logic [hpr_pkg::OUT_W-1:0]  out_rank_fraction
);

  import hpr_pkg::*;

  localparam int UA = $clog2(USER_SLOTS);
  localparam int PA = $clog2(PAGE_SLOTS);
  localparam int CW = UA + 1;
  localparam int NW = CW + FRAC_BITS;

  // the larger memory sets the clearing sweep
  localparam int CLR_N = (USER_SLOTS > PAGE_SLOTS) ? USER_SLOTS : PAGE_SLOTS;
  localparam int CLA   = $clog2(CLR_N);

  logic [CLA-1:0] clr_r;
  logic           action_r;
  logic [UA-1:0]  slot_r;
  logic [9:0]     pages_r;
  logic [CW-1:0]  known_r;
  logic [PA-1:0]  mine_r;
  logic [PA-1:0]  p_r;
  logic [CW-1:0]  fewer_r;
  logic           sum_last_r;
  logic [NW-1:0]  rem_r;
  logic [NW-1:0]  quo_r;
  logic [5:0]     dcnt_r;
  logic           out_valid_r;
  logic [OUT_W-1:0] res_r;

  logic [UA-1:0] slot_in;
  logic [UA-1:0] u_waddr;
  logic [PA-1:0] u_wdata;
  logic          u_we;
  logic [PA-1:0] u_rdata;
  logic [PA-1:0] h_raddr;
  logic [PA-1:0] h_waddr;
  logic [CW-1:0] h_wdata;
  logic [CW-1:0] h_rdata;
  logic          h_we;
  logic          valid_rec;
  logic          old_nz;

  // user ids wrap onto the user memory
  always_comb begin
    logic [31:0] ext;
    ext = 32'(in_user_id);
    slot_in = ext[UA-1:0];
  end

  assign valid_rec = (pages_r != 10'd0) && ({22'd0, pages_r} < 32'(PAGE_SLOTS));
  assign old_nz    = (u_rdata != '0);

  // clear sweep address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // user memory port
  always_comb begin
    u_we    = 1'b0;
    u_waddr = slot_r;
    u_wdata = pages_r[PA-1:0];
    if (cmd.clr_step) begin
      u_we    = 1'b1;
      u_waddr = clr_r[UA-1:0];
      u_wdata = '0;
    end else if (cmd.update) begin
      u_we = 1'b1;
    end
  end

  hpr_ram #(.WIDTH(PA), .DEPTH(USER_SLOTS)) u_user_mem (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .raddr (slot_r),
    .rdata (u_rdata)
  );

  // histogram port: read-modify-write of the old bucket is a two-pass flow
  // handled by the update sequence below; the sum sweep reads one bucket ahead
  logic [1:0]    upd_r;
  logic [PA-1:0] old_r;

  always_comb begin
    h_we    = 1'b0;
    h_waddr = p_r;
    h_wdata = '0;
    h_raddr = p_r;
    if (cmd.clr_step) begin
      h_we    = (clr_r < CLA'(PAGE_SLOTS)) || (CLR_N == PAGE_SLOTS);
      h_waddr = clr_r[PA-1:0];
    end else if (upd_r == 2'd1) begin
      h_raddr = pages_r[PA-1:0];
    end else if (upd_r == 2'd2) begin
      h_we    = (old_r != '0) && (h_rdata != '0);
      h_waddr = old_r;
      h_wdata = h_rdata - 1'b1;
      h_raddr = pages_r[PA-1:0];
    end else if (upd_r == 2'd3) begin
      h_we    = 1'b1;
      h_waddr = pages_r[PA-1:0];
      h_wdata = h_rdata + 1'b1;
    end else if (cmd.sum_step) begin
      h_raddr = p_r + 1'b1;
    end else if (cmd.update) begin
      h_raddr = u_rdata;
    end
  end

  hpr_ram #(.WIDTH(CW), .DEPTH(PAGE_SLOTS)) u_hist_mem (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // update sequencer: old bucket read, decrement, new bucket increment
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r <= '0;
    end else if (cmd.update) begin
      upd_r <= 2'd2;
    end else if (upd_r == 2'd2) begin
      upd_r <= 2'd1;
    end else if (upd_r == 2'd1) begin
      upd_r <= 2'd3;
    end else begin
      upd_r <= 2'd0;
    end
  end

  // known users and the item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r <= '0;
    end else if (cmd.update && !old_nz) begin
      known_r <= known_r + 1'b1;
    end
    if (cmd.load) begin
      action_r <= in_action;
      slot_r   <= slot_in;
      pages_r  <= in_page_count;
    end
    if (cmd.update) begin
      old_r <= u_rdata;
    end
  end

  // bucket sweep over 1 .. mine-1, one read a cycle
  always_ff @(posedge clk) begin
    if (cmd.sum_start) begin
      mine_r     <= u_rdata;
      p_r        <= PA'(1);
      fewer_r    <= '0;
      sum_last_r <= (u_rdata <= PA'(1));
    end else if (cmd.sum_step) begin
      if (!sum_last_r) begin
        fewer_r <= fewer_r + h_rdata;
      end
      p_r        <= p_r + 1'b1;
      sum_last_r <= (p_r + 1'b1 >= mine_r);
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [NW:0]   trial;
  logic [NW-1:0] divisor;
  assign divisor = NW'(known_r - 1'b1);
  always_comb begin
    trial = {rem_r, quo_r[NW-1]} - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r  <= '0;
      quo_r  <= {fewer_r, {FRAC_BITS{1'b0}}};
      dcnt_r <= 6'(NW);
    end else if (cmd.div_step && dcnt_r != '0) begin
      if (!trial[NW]) begin
        rem_r <= trial[NW-1:0];
        quo_r <= {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[NW-2:0], quo_r[NW-1]};
        quo_r <= {quo_r[NW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
    if (cmd.emit) begin
      if (u_rdata == '0) begin
        res_r <= '0;
      end else if (known_r <= CW'(1)) begin
        res_r <= OUT_W'(1) << FRAC_BITS;
      end else begin
        res_r <= quo_r[OUT_W-1:0];
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rank_fraction = res_r;

  // status back to the controller
  assign stat.clr_done  = (clr_r == CLA'(CLR_N - 1));
  assign stat.is_query  = action_r;
  assign stat.valid_rec = valid_rec;
  assign stat.unknown   = (u_rdata == '0);
  assign stat.one_user  = (known_r <= CW'(1));
  assign stat.sum_done  = sum_last_r;
  assign stat.div_done  = (dcnt_r == 6'd1);

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import hpr_pkg::*;

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;
  localparam int IDLE_LIMIT = 200000;
  localparam int NUM_RANDOM = 540;

  // rank predictor and queue of expected answers
  class rank_scoreboard;
    logic [9:0]  pages_of[USER_SLOTS];
    int unsigned users_at[PAGE_SLOTS];
    int unsigned known;
    logic [OUT_W-1:0] pending_ranks[$];
    int mismatches;

    function void clear();
      foreach (pages_of[i]) pages_of[i] = '0;
      foreach (users_at[i]) users_at[i] = 0;
      known = 0;
      mismatches = 0;
      pending_ranks.delete();
    endfunction

    function logic [OUT_W-1:0] rank_of(logic [15:0] uid);
      logic [9:0] mine;
      longint unsigned fewer;
      mine = pages_of[uid];
      fewer = 0;
      if (mine == 0) return '0;
      if (known <= 1) return OUT_W'(1 << FRAC_BITS);
      for (int p = 1; p < mine; p++) fewer += users_at[p];
      return OUT_W'((fewer << FRAC_BITS) / (known - 1));
    endfunction

    // note an accepted request
    function void note_request(logic act, logic [15:0] uid, logic [9:0] pg);
      logic [9:0] old;
      if (act == ACT_QUERY) begin
        pending_ranks.push_back(rank_of(uid));
        return;
      end
      if (pg == 0) return;
      old = pages_of[uid];
      if (old != 0) begin
        if (users_at[old] != 0) users_at[old]--;
      end else begin
        known++;
      end
      pages_of[uid] = pg;
      users_at[pg]++;
    endfunction

    function void check_rank(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (pending_ranks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected rank result %0d", got);
        return;
      end
      want = pending_ranks.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("rank mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_action = 1'b0;
  logic [15:0] in_user_id = '0;
  logic [9:0] in_page_count = '0;
  logic busy, out_valid;
  logic [OUT_W-1:0] out_rank_fraction;
  int idle_cycles = 0;
  rank_scoreboard sb;
  logic [15:0] pool[16];

  always #5 clk = ~clk;

  histogram_percentile_rank_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_user_id(in_user_id), .in_page_count(in_page_count),
    .out_valid(out_valid), .out_rank_fraction(out_rank_fraction)
  );

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_rank(out_rank_fraction);
      if (out_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    repeat (n) @(posedge clk);
  endtask

  // issue one request and wait for its acceptance
  task automatic send_request(logic act, logic [15:0] uid, logic [9:0] pg, bit gaps);
    in_action <= act;
    in_user_id <= uid;
    in_page_count <= pg;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(act, uid, pg);
    start <= 1'b0;
    @(posedge clk);
    if (gaps) idle_gap();
  endtask

  task automatic drain();
    while (sb.pending_ranks.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [15:0] uid;
    logic [9:0] pg;
    sb = new();
    sb.clear();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    send_request(ACT_QUERY, 16'd0, 10'd1, 0);
    send_request(ACT_RECORD, 16'd0, 10'd1, 0);
    send_request(ACT_QUERY, 16'd0, 10'd0, 0);
    send_request(ACT_RECORD, 16'hFFFF, 10'd1023, 0);
    send_request(ACT_QUERY, 16'hFFFF, 10'h3FF, 0);
    send_request(ACT_QUERY, 16'd0, 10'd0, 0);
    send_request(ACT_RECORD, 16'h1234, 10'd0, 0);
    send_request(ACT_QUERY, 16'h1234, 10'd5, 0);
    send_request(ACT_RECORD, 16'hAAAA, 10'h155, 0);
    send_request(ACT_RECORD, 16'h5555, 10'h2AA, 0);
    send_request(ACT_RECORD, 16'h5555, 10'h2AA, 0);
    send_request(ACT_QUERY, 16'h5555, 10'd0, 0);
    send_request(ACT_RECORD, 16'hFFFF, 10'd2, 0);
    send_request(ACT_QUERY, 16'hFFFF, 10'd0, 0);
    send_request(ACT_QUERY, 16'hAAAA, 10'd0, 0);
    send_request(ACT_QUERY, 16'h0001, 10'd0, 0);
    drain();

    // random traffic over a small user pool plus noise ids
    foreach (pool[i]) pool[i] = 16'($urandom());
    for (int i = 0; i < NUM_RANDOM; i++) begin
      uid = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : pool[$urandom_range(0, 15)];
      case ($urandom_range(0, 9))
        0:       pg = 10'($urandom());
        1:       pg = 10'd1023;
        2:       pg = 10'd0;
        default: pg = 10'($urandom_range(1, 64));
      endcase
      send_request($urandom_range(0, 1) ? ACT_QUERY : ACT_RECORD, uid, pg, 1);
      if (i == NUM_RANDOM / 2) drain();
    end

    drain();
    repeat (1200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_ranks.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
